[rtl/spv_pkg.sv]
package spv_pkg;

	// Input item opcodes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SETPOS = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_VOLUME = 3'd0;
	localparam logic [2:0] REG_PAN    = 3'd1;
	localparam logic [2:0] REG_STEP   = 3'd2;
	localparam logic [2:0] REG_LOOP   = 3'd3;
	localparam logic [2:0] REG_STEREO = 3'd4;
	localparam logic [2:0] REG_CLIP   = 3'd5;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam int OPCODE_W  = 2;
	localparam int ADDR_IN_W = 16;
	localparam int SAMPLE_W  = 16;
	localparam int VOLUME_W  = 16;
	localparam int PAN_W     = 17;
	localparam int STEP_W    = 24;
	localparam int FRAME_W   = 17;
	localparam int FRAC_W    = 16;
	localparam int POS_W     = FRAME_W + FRAC_W;
	localparam int FACTOR_W  = 16;
	localparam int GAIN_W    = 31;
	localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
	localparam int SHIFT     = 30;
	localparam int CONTR_W   = PROD_W - SHIFT;

	localparam logic signed [PAN_W-1:0] PAN_MAX = 17'sd32768;
	localparam logic signed [PAN_W-1:0] PAN_MIN = -17'sd32768;
	localparam logic [FACTOR_W-1:0] Q15_ONE = 16'd32768;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = 48'sd536870912;

	// Control of the sample store for one cycle
	typedef struct packed {
		logic wr_en;
		logic wr_bank;
		logic rd_en;
	} spv_store_ctl_t;

endpackage

[rtl/spv_cmd_if.sv]
interface spv_cmd_if #(
	parameter int MIX_BITS = 24
);
	import spv_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [OPCODE_W-1:0]         opcode;
	logic [ADDR_IN_W-1:0]        load_address;
	logic signed [SAMPLE_W-1:0]  load_data;
	logic [ADDR_IN_W-1:0]        start_position;
	logic signed [MIX_BITS-1:0]  mix_left_in;
	logic signed [MIX_BITS-1:0]  mix_right_in;

	modport source (
		output valid, opcode, load_address, load_data, start_position,
		       mix_left_in, mix_right_in,
		input  ready
	);

	modport sink (
		input  valid, opcode, load_address, load_data, start_position,
		       mix_left_in, mix_right_in,
		output ready
	);

endinterface

[rtl/spv_res_if.sv]
interface spv_res_if #(
	parameter int MIX_BITS = 24
);
	import spv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [MIX_BITS-1:0] mix_left_out;
	logic signed [MIX_BITS-1:0] mix_right_out;
	logic [FRAME_W-1:0]         position;
	logic                       stopped;

	modport source (
		output valid, mix_left_out, mix_right_out, position, stopped,
		input  ready
	);

	modport sink (
		input  valid, mix_left_out, mix_right_out, position, stopped,
		output ready
	);

endinterface

[rtl/sample_playback_voice_top.sv]
// An item's result passes through stage 1, stage 2 and the output register.
// Throughput: one item per cycle while the result side accepts; the 33-bit position
// add and clip-end compare that picks the next frame closes in the transfer cycle itself.
// Reset (arst_n low, asynchronous) clears position, stopped flag and the
// pipeline valids and loads the register defaults; sample memory contents stay undefined.
module sample_playback_voice_top #(
	parameter int STORE_WORDS = 65536,  // power of two
	parameter int MIX_BITS    = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	spv_cmd_if.sink                           cmd,
	spv_res_if.source                         res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spv_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [spv_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [spv_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import spv_pkg::*;

	localparam int AW    = $clog2(STORE_WORDS);
	localparam int IDX_W = AW - 1;
	localparam int XW    = (AW > FRAME_W) ? AW : FRAME_W;
	localparam int SUM_W = MIX_BITS + 1;

	localparam logic signed [MIX_BITS-1:0] MIX_MAX = {1'b0, {(MIX_BITS-1){1'b1}}};
	localparam logic signed [MIX_BITS-1:0] MIX_MIN = {1'b1, {(MIX_BITS-1){1'b0}}};

	// ------------------------------------------------------------------
	// Configuration registers, APB-style; writes land on the access phase
	// ------------------------------------------------------------------
	logic [VOLUME_W-1:0]       volume_q;
	logic signed [PAN_W-1:0]   pan_q;
	logic [STEP_W-1:0]         step_q;
	logic                      loop_q;
	logic                      stereo_q;
	logic [FRAME_W-1:0]        clip_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= Q15_ONE;
			pan_q    <= '0;
			step_q   <= STEP_W'(65536);
			loop_q   <= 1'b0;
			stereo_q <= 1'b0;
			clip_q   <= FRAME_W'(65536);
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_VOLUME: volume_q <= pwdata[VOLUME_W-1:0];
				REG_PAN:    pan_q    <= $signed(pwdata[PAN_W-1:0]);
				REG_STEP:   step_q   <= pwdata[STEP_W-1:0];
				REG_LOOP:   loop_q   <= pwdata[0];
				REG_STEREO: stereo_q <= pwdata[0];
				REG_CLIP:   clip_q   <= pwdata[FRAME_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_VOLUME: prdata = CFG_DATA_W'(volume_q);
			REG_PAN:    prdata = CFG_DATA_W'(unsigned'(pan_q));
			REG_STEP:   prdata = CFG_DATA_W'(step_q);
			REG_LOOP:   prdata = CFG_DATA_W'(loop_q);
			REG_STEREO: prdata = CFG_DATA_W'(stereo_q);
			REG_CLIP:   prdata = CFG_DATA_W'(clip_q);
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Channel gains. Clamp pan to +/-1.0 and attenuate the far side only.
	// Registered once per cycle from the config; an item uses them when it moves
	// from stage 1 into stage 2, so a write that lands before its transfer is seen.
	// ------------------------------------------------------------------
	logic signed [PAN_W-1:0] pan_c;
	logic [FACTOR_W-1:0]     fac_l, fac_r;
	logic [GAIN_W-1:0]       gain_l_q, gain_r_q;

	always_comb begin
		if (pan_q > PAN_MAX) begin
			pan_c = PAN_MAX;
		end else if (pan_q < PAN_MIN) begin
			pan_c = PAN_MIN;
		end else begin
			pan_c = pan_q;
		end
		fac_l = (pan_c > 0) ? FACTOR_W'(PAN_MAX - pan_c) : Q15_ONE;
		fac_r = (pan_c < 0) ? FACTOR_W'(PAN_MAX + pan_c) : Q15_ONE;
	end

	always_ff @(posedge clk) begin
		gain_l_q <= GAIN_W'(volume_q * fac_l);
		gain_r_q <= GAIN_W'(volume_q * fac_r);
	end

	// ------------------------------------------------------------------
	// Stall chain: each stage advances when it is empty or the next one moves.
	// The output register lets a new item in while a result waits.
	// ------------------------------------------------------------------
	logic v1_q, v2_q, res_valid_q;
	logic en1, en2, en_out, xfer;

	assign en_out    = !res_valid_q || res.ready;
	assign en2       = !v2_q || en_out;
	assign en1       = !v1_q || en2;
	assign cmd.ready = en1;
	assign xfer      = cmd.valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en1)    v1_q        <= cmd.valid;
			if (en2)    v2_q        <= v1_q;
			if (en_out) res_valid_q <= v2_q;
		end
	end

	// ------------------------------------------------------------------
	// Play state, updated in the transfer cycle so back-to-back renders
	// each see the position left by the one before.
	// ------------------------------------------------------------------
	logic [POS_W-1:0] pos_q, pos_nxt, pos_adv;
	logic             stopped_q, stopped_nxt;
	logic             is_render, active;

	assign is_render = (cmd.opcode == OP_RENDER);
	assign active    = is_render && !stopped_q;
	assign pos_adv   = pos_q + POS_W'(step_q);

	always_comb begin
		pos_nxt     = pos_q;
		stopped_nxt = stopped_q;
		unique case (cmd.opcode)
			OP_SETPOS: begin
				pos_nxt     = {1'b0, cmd.start_position, {FRAC_W{1'b0}}};
				stopped_nxt = 1'b0;
			end
			OP_RENDER: begin
				if (!stopped_q) begin
					pos_nxt = pos_adv;
					// clip end: wrap to the fraction when looping, else halt
					if (pos_adv >= {clip_q, {FRAC_W{1'b0}}}) begin
						if (loop_q) begin
							pos_nxt = {{FRAME_W{1'b0}}, pos_adv[FRAC_W-1:0]};
						end else begin
							stopped_nxt = 1'b1;
						end
					end
				end
			end
			OP_LOAD, OP_NOP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			stopped_q <= 1'b0;
		end else if (xfer) begin
			pos_q     <= pos_nxt;
			stopped_q <= stopped_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Sample store: word address splits into bank (bit 0) and row.
	// Mono frame f sits at word f; stereo frame f at words 2f and 2f+1,
	// which is row f in both banks.
	// ------------------------------------------------------------------
	logic [XW-1:0]         frame_x, load_x;
	logic [IDX_W-1:0]      rd_idx;
	logic [SAMPLE_W-1:0]   rd_even, rd_odd;
	spv_store_ctl_t        store_ctl;

	assign frame_x = XW'(pos_q[POS_W-1:FRAC_W]);
	assign load_x  = XW'(cmd.load_address);
	assign rd_idx  = stereo_q ? frame_x[IDX_W-1:0] : frame_x[AW-1:1];

	assign store_ctl.wr_en   = xfer && (cmd.opcode == OP_LOAD);
	assign store_ctl.wr_bank = load_x[0];
	assign store_ctl.rd_en   = en1;

	spv_store #(
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.ctl     (store_ctl),
		.wr_idx  (load_x[AW-1:1]),
		.wr_data (cmd.load_data),
		.rd_idx  (rd_idx),
		.rd_even (rd_even),
		.rd_odd  (rd_odd)
	);

	// ------------------------------------------------------------------
	// Stage 1: item fields travel beside the registered memory read
	// ------------------------------------------------------------------
	logic                       render_s1, active_s1, stereo_s1, bank_s1;
	logic signed [MIX_BITS-1:0] mix_l_s1, mix_r_s1;
	logic [FRAME_W-1:0]         pos_s1;
	logic                       stopped_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			render_s1  <= is_render;
			active_s1  <= active;
			stereo_s1  <= stereo_q;
			bank_s1    <= frame_x[0];
			mix_l_s1   <= cmd.mix_left_in;
			mix_r_s1   <= cmd.mix_right_in;
			pos_s1     <= pos_nxt[POS_W-1:FRAC_W];
			stopped_s1 <= stopped_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: pick the channel samples and scale by the gains
	// ------------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] smp_l, smp_r;
	logic signed [PROD_W-1:0]   prod_l_s2, prod_r_s2;
	logic                       render_s2, active_s2;
	logic signed [MIX_BITS-1:0] mix_l_s2, mix_r_s2;
	logic [FRAME_W-1:0]         pos_s2;
	logic                       stopped_s2;

	always_comb begin
		if (stereo_s1) begin
			smp_l = $signed(rd_even);
			smp_r = $signed(rd_odd);
		end else begin
			smp_l = $signed(bank_s1 ? rd_odd : rd_even);
			smp_r = smp_l;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_l_s2  <= smp_l * $signed({1'b0, gain_l_q});
			prod_r_s2  <= smp_r * $signed({1'b0, gain_r_q});
			render_s2  <= render_s1;
			active_s2  <= active_s1;
			mix_l_s2   <= mix_l_s1;
			mix_r_s2   <= mix_r_s1;
			pos_s2     <= pos_s1;
			stopped_s2 <= stopped_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: round to nearest (ties up), add to the mix, saturate
	// ------------------------------------------------------------------
	function automatic logic signed [MIX_BITS-1:0] mix_add(
		input logic signed [MIX_BITS-1:0] mix,
		input logic signed [PROD_W-1:0]   prod,
		input logic                       use_prod
	);
		logic signed [PROD_W-1:0]  rnd;
		logic signed [CONTR_W-1:0] contr;
		logic signed [SUM_W-1:0]   sum;
		rnd   = prod + ROUND_BIAS;
		contr = use_prod ? rnd[PROD_W-1:SHIFT] : '0;
		sum   = SUM_W'(mix) + SUM_W'(contr);
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			mix_add = sum[SUM_W-1] ? MIX_MIN : MIX_MAX;
		end else begin
			mix_add = sum[MIX_BITS-1:0];
		end
	endfunction

	logic signed [MIX_BITS-1:0] mix_l_q, mix_r_q;
	logic [FRAME_W-1:0]         pos_out_q;
	logic                       stopped_out_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			// non-render items report zero mix; a stopped voice passes the mix through
			mix_l_q       <= render_s2 ? mix_add(mix_l_s2, prod_l_s2, active_s2) : '0;
			mix_r_q       <= render_s2 ? mix_add(mix_r_s2, prod_r_s2, active_s2) : '0;
			pos_out_q     <= pos_s2;
			stopped_out_q <= stopped_s2;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.mix_left_out  = mix_l_q;
	assign res.mix_right_out = mix_r_q;
	assign res.position      = pos_out_q;
	assign res.stopped       = stopped_out_q;

endmodule

[rtl/spv_store.sv]
module spv_store #(
	parameter int IDX_W = 15
) (
	input  logic                              clk,
	input  spv_pkg::spv_store_ctl_t           ctl,
	input  logic [IDX_W-1:0]                  wr_idx,
	input  logic [spv_pkg::SAMPLE_W-1:0]      wr_data,
	input  logic [IDX_W-1:0]                  rd_idx,
	output logic [spv_pkg::SAMPLE_W-1:0]      rd_even,
	output logic [spv_pkg::SAMPLE_W-1:0]      rd_odd
);
	import spv_pkg::*;

	localparam int DEPTH = 1 << IDX_W;

	// Even and odd words live in separate banks so both words of a stereo frame read together
	logic [SAMPLE_W-1:0] even_mem [DEPTH];
	logic [SAMPLE_W-1:0] odd_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en && !ctl.wr_bank) begin
			even_mem[wr_idx] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_even <= even_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_bank) begin
			odd_mem[wr_idx] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_odd <= odd_mem[rd_idx];
		end
	end

endmodule
